// File: rtl/cte_pkg.sv
// credential table engine package: operation and status codes, controller interface structs
// no dependencies
package cte_pkg;
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_ERASE = 3'd1;
	localparam logic [2:0] OP_EDIT = 3'd2;
	localparam logic [2:0] OP_VALIDATE = 3'd3;
	localparam logic [2:0] OP_GET = 3'd4;
	localparam logic [2:0] OP_SET = 3'd5;
	localparam logic [2:0] OP_FORMAT = 3'd6;
	localparam logic [2:0] OP_UNKNOWN = 3'd7;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMERG = 3'd1;
	localparam logic [2:0] ST_EXISTS = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_BADPASS = 3'd5;

	localparam logic [1:0] WHICH_FIRST = 2'd0;
	localparam logic [1:0] WHICH_SECOND = 2'd1;
	localparam logic [1:0] WHICH_BOTH = 2'd2;

	localparam logic [7:0] BYTE_MASK = 8'hff;

	typedef struct packed {
		logic load;      // capture request fields, clear scan
		logic scan_step; // examine the current index, advance
		logic rd_issue;  // read the memory at the found index
		logic commit;    // perform the write and produce the result
		logic fmt_step;  // clear one used mark
	} cte_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic fmt_last;
	} cte_stat_t;
endpackage

// File: rtl/credential_table_engine_core.sv
// credential table engine top level: configuration register, controller and datapath
// depends on cte_pkg, cte_ctrl, cte_dp
//
// one operation at a time: start is taken when busy is low, and the result appears on the
// result ports for a single cycle marked by done; the receiver cannot stall it. lookups,
// add, erase, edit, validate, get and set scan every entry through the record memory's read
// port, one entry a cycle, then wait, read the found record and commit. format clears the
// used marks one a cycle, then commits. operations refused in emergency mode and unknown
// codes skip the scan and go from the decide state straight to commit. no clearing pass after
// reset: the used marks are flip-flops cleared at once.
module credential_table_engine_core import cte_pkg::*; #(
	parameter int MAX_USERS = 256,
	parameter int ID_BYTES = 8,
	parameter int PASS_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [63:0] user_id,
	input  logic [31:0] presented_password,
	input  logic [31:0] new_first_password,
	input  logic [31:0] new_second_password,
	input  logic [15:0] devices_in,
	input  logic [1:0]  edit_which,
	input  logic        check_password,
	output logic        done,
	output logic [2:0]  status,
	output logic [1:0]  matched_password,
	output logic [15:0] devices_out,
	output logic [8:0]  unused_entries
);
	logic emergency_q;
	cte_cmd_t cmd;
	cte_stat_t stat;
	logic quick, fmt;

	// emergency register: the user must write it only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emergency_q <= 1'b0;
		else if (cfg_we) emergency_q <= cfg_wdata;
	end

	cte_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.quick (quick),
		.fmt   (fmt),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	cte_dp #(
		.MAX_USERS (MAX_USERS),
		.ID_BYTES  (ID_BYTES),
		.PASS_BYTES(PASS_BYTES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.emergency_mode     (emergency_q),
		.operation          (operation),
		.user_id            (user_id),
		.presented_password (presented_password),
		.new_first_password (new_first_password),
		.new_second_password(new_second_password),
		.devices_in         (devices_in),
		.edit_which         (edit_which),
		.check_password     (check_password),
		.quick              (quick),
		.fmt                (fmt),
		.stat               (stat),
		.done               (done),
		.status             (status),
		.matched_password   (matched_password),
		.devices_out        (devices_out),
		.unused_entries     (unused_entries)
	);

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transfer not taken");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result held twice");
`endif
endmodule

// File: rtl/cte_ctrl.sv
// credential table engine controller: sequences scan, read, commit and format sweep
// depends on cte_pkg
module cte_ctrl import cte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      quick,
	input  logic      fmt,
	input  cte_stat_t stat,
	output logic      busy,
	output cte_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;
	localparam logic [2:0] S_FMT = 3'd5;
	localparam logic [2:0] S_DECIDE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (quick) state_d = S_COMMIT;
				else if (fmt) state_d = S_FMT;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = S_WAIT;
			end
			// lets the compare of the last entry settle the found index
			S_WAIT: state_d = S_READ;
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_IDLE;
			end
			S_FMT: begin
				cmd.fmt_step = 1'b1;
				if (stat.fmt_last) state_d = S_COMMIT;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("more than one command");
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !busy) else $error("busy after commit");
	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> cmd.load) else $error("start not loaded");
`endif
endmodule

// File: rtl/cte_dp.sv
// credential table engine datapath: record memory, used marks, scan and result registers
// depends on cte_pkg
module cte_dp import cte_pkg::*; #(
	parameter int MAX_USERS = 256,
	parameter int ID_BYTES = 8,
	parameter int PASS_BYTES = 4,
	localparam int IW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1,
	localparam int CW = $clog2(MAX_USERS + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cte_cmd_t    cmd,
	input  logic        emergency_mode,
	input  logic [2:0]  operation,
	input  logic [63:0] user_id,
	input  logic [31:0] presented_password,
	input  logic [31:0] new_first_password,
	input  logic [31:0] new_second_password,
	input  logic [15:0] devices_in,
	input  logic [1:0]  edit_which,
	input  logic        check_password,
	output logic        quick,
	output logic        fmt,
	output cte_stat_t   stat,
	output logic        done,
	output logic [2:0]  status,
	output logic [1:0]  matched_password,
	output logic [15:0] devices_out,
	output logic [8:0]  unused_entries
);
	localparam int IDB = (ID_BYTES >= 8) ? 8 : ID_BYTES;
	localparam int PB = (PASS_BYTES >= 4) ? 4 : PASS_BYTES;
	localparam logic [63:0] KEY_MASK = (IDB >= 8) ? {64{1'b1}} : ((64'd1 << (8 * IDB)) - 64'd1);
	localparam logic [31:0] PASS_MASK = (PB >= 4) ? {32{1'b1}} : ((32'd1 << (8 * PB)) - 32'd1);
	localparam logic [IW-1:0] LAST = IW'(MAX_USERS - 1);
	localparam int RW = 8 + 64 + 32 + 32 + 16;

	logic [MAX_USERS-1:0] used_q;
	logic [RW-1:0] mem_q [MAX_USERS];
	logic [RW-1:0] rd_q;
	logic [RW-1:0] wr_data;
	logic wr_en;
	logic [IW-1:0] wr_addr;

	logic [2:0] op_q;
	logic [63:0] key_q;
	logic [7:0] sig_q;
	logic [31:0] pres_q, p0_q, p1_q;
	logic [15:0] dl_q;
	logic [1:0] which_q;
	logic chk_q;
	logic [IW-1:0] idx_q, found_idx_q, free_idx_q;
	logic found_q, have_free_q;
	logic [CW-1:0] free_q;

	logic [7:0] sig_d;
	always_comb begin
		sig_d = '0;
		for (int i = 0; i < IDB; i++) sig_d = sig_d + (user_id[8*i +: 8] & BYTE_MASK);
	end

	// control requests the fast path when refused or unknown operation
	logic modifying;
	assign modifying = (op_q == OP_ADD) || (op_q == OP_ERASE) || (op_q == OP_EDIT)
		|| (op_q == OP_FORMAT);
	assign quick = (modifying && emergency_mode) || (op_q == OP_UNKNOWN);
	assign fmt = (op_q == OP_FORMAT);
	assign stat.scan_last = (idx_q == LAST);
	assign stat.fmt_last = (idx_q == LAST);

	// stored record fields
	logic [31:0] m_p0, m_p1;
	logic [15:0] m_dl;
	assign {m_p0, m_p1, m_dl} = rd_q[79:0];

	// scan compare: used mark is in flip-flops, record through a registered read
	logic [RW-1:0] scan_rd_q;
	logic scan_v_s1;
	logic [IW-1:0] scan_idx_s1;
	logic scan_used_s1;
	logic hit_s1;
	assign hit_s1 = scan_v_s1 && scan_used_s1 && (scan_rd_q[RW-1 -: 8] == sig_q)
		&& (scan_rd_q[RW-9 -: 64] == key_q);

	always_ff @(posedge clk) begin
		if (cmd.scan_step) scan_rd_q <= mem_q[idx_q];
		if (cmd.rd_issue) rd_q <= mem_q[found_idx_q];
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan_step;
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= idx_q;
		scan_used_s1 <= used_q[idx_q];
	end

	// commit decisions
	logic [1:0] m_match;
	logic [2:0] st_d;
	logic [1:0] mt_d;
	logic [15:0] do_d;
	logic set_used, clr_used;
	always_comb begin
		if ((m_p0 & PASS_MASK) == (pres_q & PASS_MASK)) m_match = 2'd1;
		else if ((m_p1 & PASS_MASK) == (pres_q & PASS_MASK)) m_match = 2'd2;
		else m_match = 2'd0;
		st_d = ST_OK;
		mt_d = 2'd0;
		do_d = '0;
		wr_en = 1'b0;
		wr_addr = found_idx_q;
		wr_data = rd_q;
		set_used = 1'b0;
		clr_used = 1'b0;
		if (cmd.commit) begin
			if (quick) begin
				st_d = (op_q == OP_UNKNOWN) ? ST_OK : ST_EMERG;
			end else begin
				case (op_q)
					OP_ADD: begin
						if (found_q) st_d = ST_EXISTS;
						else if (!have_free_q) st_d = ST_FULL;
						else begin
							wr_en = 1'b1;
							wr_addr = free_idx_q;
							wr_data = {sig_q, key_q, p0_q, p1_q, dl_q};
							set_used = 1'b1;
						end
					end
					OP_FORMAT: st_d = ST_OK;
					default: begin
						if (!found_q) st_d = ST_NOTFOUND;
						else begin
							case (op_q)
								OP_ERASE: clr_used = 1'b1;
								OP_EDIT: begin
									if (chk_q) begin
										mt_d = m_match;
										if (m_match == 2'd0) st_d = ST_BADPASS;
									end
									if (!chk_q || m_match != 2'd0) begin
										wr_en = 1'b1;
										if (which_q == WHICH_FIRST || which_q == WHICH_BOTH)
											wr_data[79:48] = p0_q;
										if (which_q == WHICH_SECOND || which_q == WHICH_BOTH)
											wr_data[47:16] = p1_q;
									end
								end
								OP_VALIDATE: begin
									mt_d = m_match;
									if (m_match == 2'd0) st_d = ST_BADPASS;
									else do_d = m_dl;
								end
								OP_GET: do_d = m_dl;
								OP_SET: begin
									wr_en = 1'b1;
									wr_data[15:0] = dl_q;
								end
								default: st_d = ST_OK;
							endcase
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			key_q <= user_id & KEY_MASK;
			sig_q <= sig_d;
			pres_q <= presented_password;
			p0_q <= new_first_password;
			p1_q <= new_second_password;
			dl_q <= devices_in;
			which_q <= edit_which;
			chk_q <= check_password;
		end
		if (cmd.commit) begin
			status <= st_d;
			matched_password <= mt_d;
			devices_out <= do_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			free_q <= CW'(MAX_USERS);
			idx_q <= '0;
			found_q <= 1'b0;
			have_free_q <= 1'b0;
			found_idx_q <= '0;
			free_idx_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.commit;
			if (cmd.load) begin
				idx_q <= '0;
				found_q <= 1'b0;
				have_free_q <= 1'b0;
			end
			if (cmd.scan_step || cmd.fmt_step) idx_q <= idx_q + 1'b1;
			if (cmd.scan_step && !have_free_q && !used_q[idx_q]) begin
				have_free_q <= 1'b1;
				free_idx_q <= idx_q;
			end
			if (hit_s1 && !found_q) begin
				found_q <= 1'b1;
				found_idx_q <= scan_idx_s1;
			end
			if (cmd.fmt_step) used_q[idx_q] <= 1'b0;
			if (cmd.commit && fmt && !quick) free_q <= CW'(MAX_USERS);
			if (set_used) begin
				used_q[free_idx_q] <= 1'b1;
				free_q <= free_q - 1'b1;
			end
			if (clr_used) begin
				used_q[found_idx_q] <= 1'b0;
				free_q <= free_q + 1'b1;
			end
		end
	end

	assign unused_entries = (free_q > CW'(511)) ? 9'd511 : 9'(free_q);

`ifndef NO_ASSERTIONS
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CW'(MAX_USERS)) else $error("free count beyond table size");
	a_add_free: assert property (@(posedge clk) disable iff (!arst_n)
		set_used |-> !used_q[free_idx_q]) else $error("add into used slot");
	a_erase_used: assert property (@(posedge clk) disable iff (!arst_n)
		clr_used |-> used_q[found_idx_q]) else $error("erase of unused slot");
`endif
endmodule

// File: sim/credential_table_engine_core_tb.sv
// testbench for credential_table_engine_core: directed and random credential operations
// checked against an in-bench model of the record table; depends on cte_pkg and the rtl
`timescale 1ns / 1ps

module credential_table_engine_core_tb;
	import cte_pkg::*;

	localparam int N_ENTRIES = 256;
	localparam int LIMIT_CYCLES = 2000000;
	localparam logic [1:0] WHICH_NONE = 2'd3;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  matched;
		logic [15:0] devs;
		logic [8:0]  free_cnt;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  operation = '0;
	logic [63:0] user_id = '0;
	logic [31:0] presented_password = '0;
	logic [31:0] new_first_password = '0;
	logic [31:0] new_second_password = '0;
	logic [15:0] devices_in = '0;
	logic [1:0]  edit_which = '0;
	logic        check_password = 1'b0;
	logic        done;
	logic [2:0]  status;
	logic [1:0]  matched_password;
	logic [15:0] devices_out;
	logic [8:0]  unused_entries;

	// model of the record table
	logic        emerg;
	logic        rec_used [N_ENTRIES];
	logic [63:0] rec_key [N_ENTRIES];
	logic [31:0] rec_pw1 [N_ENTRIES];
	logic [31:0] rec_pw2 [N_ENTRIES];
	logic [15:0] rec_devs [N_ENTRIES];

	answer_t pending_answers[$];
	int      fail_count = 0;
	int      cycle_count = 0;
	int      idle_pct = 0;
	logic [63:0] known_ids[$];

	credential_table_engine_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .operation(operation), .user_id(user_id),
		.presented_password(presented_password), .new_first_password(new_first_password),
		.new_second_password(new_second_password), .devices_in(devices_in),
		.edit_which(edit_which), .check_password(check_password), .done(done),
		.status(status), .matched_password(matched_password),
		.devices_out(devices_out), .unused_entries(unused_entries)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// result checker: done strobes one cycle, compare with oldest prediction
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result", status, 0);
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (matched_password !== want.matched)
					report_mismatch("matched", matched_password, want.matched);
				if (devices_out !== want.devs) report_mismatch("devices", devices_out, want.devs);
				if (unused_entries !== want.free_cnt)
					report_mismatch("free count", unused_entries, want.free_cnt);
			end
		end
	end

	function automatic int lookup_entry(input logic [63:0] id);
		for (int i = 0; i < N_ENTRIES; i++)
			if (rec_used[i] && rec_key[i] == id) return i;
		return -1;
	endfunction

	function automatic logic [1:0] password_hit(input int idx, input logic [31:0] pw);
		if (rec_pw1[idx] == pw) return 2'd1;
		if (rec_pw2[idx] == pw) return 2'd2;
		return 2'd0;
	endfunction

	// works out the answer of one operation and updates the table model
	function automatic answer_t apply_operation(input logic [2:0] op, input logic [63:0] id,
			input logic [31:0] pw, input logic [31:0] p1, input logic [31:0] p2,
			input logic [15:0] dl, input logic [1:0] which, input logic chk);
		answer_t a;
		int idx;
		int nfree;
		a = '0;
		a.status = ST_OK;
		if (emerg && (op == OP_ADD || op == OP_ERASE || op == OP_EDIT || op == OP_FORMAT)) begin
			a.status = ST_EMERG;
		end else if (op == OP_ADD) begin
			if (lookup_entry(id) >= 0) begin
				a.status = ST_EXISTS;
			end else begin
				idx = -1;
				for (int i = 0; i < N_ENTRIES && idx < 0; i++)
					if (!rec_used[i]) idx = i;
				if (idx < 0) begin
					a.status = ST_FULL;
				end else begin
					rec_used[idx] = 1'b1;
					rec_key[idx] = id;
					rec_pw1[idx] = p1;
					rec_pw2[idx] = p2;
					rec_devs[idx] = dl;
				end
			end
		end else if (op == OP_FORMAT) begin
			for (int i = 0; i < N_ENTRIES; i++) rec_used[i] = 1'b0;
		end else if (op != OP_UNKNOWN) begin
			idx = lookup_entry(id);
			if (idx < 0) begin
				a.status = ST_NOTFOUND;
			end else begin
				case (op)
					OP_ERASE: rec_used[idx] = 1'b0;
					OP_EDIT: begin
						if (chk) begin
							a.matched = password_hit(idx, pw);
							if (a.matched == 2'd0) a.status = ST_BADPASS;
						end
						if (a.status == ST_OK) begin
							if (which == WHICH_FIRST || which == WHICH_BOTH) rec_pw1[idx] = p1;
							if (which == WHICH_SECOND || which == WHICH_BOTH) rec_pw2[idx] = p2;
						end
					end
					OP_VALIDATE: begin
						a.matched = password_hit(idx, pw);
						if (a.matched == 2'd0) a.status = ST_BADPASS;
						else a.devs = rec_devs[idx];
					end
					OP_GET: a.devs = rec_devs[idx];
					default: rec_devs[idx] = dl;
				endcase
			end
		end
		nfree = 0;
		for (int i = 0; i < N_ENTRIES; i++) if (!rec_used[i]) nfree++;
		a.free_cnt = 9'(nfree);
		return a;
	endfunction

	// one transfer, with a random gap before it in idle phases
	task automatic send_item(input logic [2:0] op, input logic [63:0] id, input logic [31:0] pw,
			input logic [31:0] p1, input logic [31:0] p2, input logic [15:0] dl,
			input logic [1:0] which, input logic chk);
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		operation = op;
		user_id = id;
		presented_password = pw;
		new_first_password = p1;
		new_second_password = p2;
		devices_in = dl;
		edit_which = which;
		check_password = chk;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_answers.push_back(apply_operation(op, id, pw, p1, p2, dl, which, chk));
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_emergency(input logic v);
		drain();
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		emerg = v;
	endtask

	function automatic logic [63:0] rand_id;
		return {$urandom, $urandom};
	endfunction

	task automatic test_directed;
		send_item(OP_ADD, '1, '1, '1, '0, '1, WHICH_FIRST, 1'b0);
		send_item(OP_ADD, '0, '0, 32'h1234, 32'hffff_ffff, '0, WHICH_FIRST, 1'b0);
		send_item(OP_ADD, '1, '0, '0, '0, '0, WHICH_FIRST, 1'b0);             // exists
		send_item(OP_VALIDATE, '1, '1, '0, '0, '0, WHICH_FIRST, 1'b0);        // first matches
		send_item(OP_VALIDATE, '0, 32'hffff_ffff, '0, '0, '0, WHICH_FIRST, 1'b0); // second
		send_item(OP_VALIDATE, '0, 32'h5, '0, '0, '0, WHICH_FIRST, 1'b0);     // bad password
		send_item(OP_VALIDATE, 64'h55, '0, '0, '0, '0, WHICH_FIRST, 1'b0);    // not found
		send_item(OP_GET, '1, '0, '0, '0, '0, WHICH_FIRST, 1'b0);
		send_item(OP_SET, '1, '0, '0, '0, 16'h0, WHICH_FIRST, 1'b0);
		send_item(OP_EDIT, '1, 32'h7, 32'haa, 32'hbb, '0, WHICH_BOTH, 1'b1);  // bad check
		send_item(OP_EDIT, '1, '1, 32'haa, 32'hbb, '0, WHICH_BOTH, 1'b1);
		send_item(OP_EDIT, '0, '0, 32'h11, 32'h22, '0, WHICH_SECOND, 1'b0);
		send_item(OP_EDIT, '0, '0, 32'h11, 32'h22, '0, WHICH_NONE, 1'b0);     // no change
		send_item(OP_EDIT, '0, '0, 32'h33, 32'h44, '0, WHICH_FIRST, 1'b0);
		send_item(OP_VALIDATE, '0, 32'h22, '0, '0, '0, WHICH_FIRST, 1'b0);
		send_item(OP_UNKNOWN, '1, '0, '0, '0, '0, WHICH_FIRST, 1'b0);
		send_item(OP_ERASE, '1, '0, '0, '0, '0, WHICH_FIRST, 1'b0);
		send_item(OP_ERASE, '1, '0, '0, '0, '0, WHICH_FIRST, 1'b0);           // not found
		send_item(OP_FORMAT, '0, '0, '0, '0, '0, WHICH_FIRST, 1'b0);
		// two ids with the same byte sum must stay apart
		send_item(OP_ADD, 64'h0102, '0, '0, '0, 16'h1, WHICH_FIRST, 1'b0);
		send_item(OP_GET, 64'h0201, '0, '0, '0, '0, WHICH_FIRST, 1'b0);
	endtask

	task automatic test_emergency;
		write_emergency(1'b1);
		for (int op = 0; op < 8; op++)
			send_item(3'(op), 64'h0102, '0, '0, '0, 16'hffff, WHICH_BOTH, 1'b0);
		write_emergency(1'b0);
	endtask

	// fills the table past full, then checks a few entries and formats
	task automatic test_full_table;
		for (int i = 0; i < N_ENTRIES + 2; i++)
			send_item(OP_ADD, rand_id(), $urandom, $urandom, $urandom, 16'($urandom),
				WHICH_FIRST, 1'b0);
		send_item(OP_GET, 64'h0102, '0, '0, '0, '0, WHICH_FIRST, 1'b0);
		send_item(OP_ERASE, 64'h0102, '0, '0, '0, '0, WHICH_FIRST, 1'b0);
		send_item(OP_ADD, 64'hdead, '0, '0, '0, '0, WHICH_FIRST, 1'b0);
		send_item(OP_FORMAT, '0, '0, '0, '0, '0, WHICH_FIRST, 1'b0);
	endtask

	// mostly operations on known ids, some noise ids
	task automatic test_random(input int count);
		logic [63:0] id;
		logic [31:0] pw;
		logic [2:0]  op;
		int          pick;
		for (int n = 0; n < count; n++) begin
			if (known_ids.size() != 0 && $urandom_range(99) < 75)
				id = known_ids[$urandom_range(known_ids.size() - 1)];
			else
				id = rand_id();
			pick = $urandom_range(99);
			if (pick < 30) op = OP_ADD;
			else if (pick < 40) op = OP_ERASE;
			else if (pick < 55) op = OP_EDIT;
			else if (pick < 75) op = OP_VALIDATE;
			else if (pick < 85) op = OP_GET;
			else if (pick < 95) op = OP_SET;
			else if (pick < 97) op = OP_UNKNOWN;
			else op = OP_FORMAT;
			if (op == OP_ADD && known_ids.size() < 64) known_ids.push_back(id);
			pw = $urandom;
			if ($urandom_range(2) != 0) pw = 32'($urandom_range(3));
			send_item(op, id, pw, 32'($urandom_range(3)), 32'($urandom_range(3)),
				16'($urandom), 2'($urandom_range(3)), 1'($urandom));
		end
	endtask

	initial begin
		emerg = 1'b0;
		for (int i = 0; i < N_ENTRIES; i++) rec_used[i] = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_emergency();
		test_full_table();
		idle_pct = 0;
		test_random(350);
		idle_pct = 73;
		test_random(350);
		write_emergency(1'b1);
		test_random(150);
		write_emergency(1'b0);
		idle_pct = 24;
		test_random(350);
		idle_pct = 0;
		test_random(200);
		drain();
		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
